[design/tbg_pkg.sv]
// ----------------------------------------------------------------------------
// tbg_pkg: shared types and constants for the time base generator
// Holds the instruction codes, the request struct and the interval reset table.
// ----------------------------------------------------------------------------
package tbg_pkg;

    localparam int DATA_WIDTH        = 16;
    localparam int CFG_WIDTH         = 26;
    localparam int CFG_INDEX_WIDTH   = 4;
    localparam int RATE_SEL_WIDTH    = 3;
    localparam int MAX_RATES         = 8;
    localparam int DEF_COUNT_WIDTH   = 26;
    localparam int DEF_NUM_RATES     = 8;

    // Value that the overrun bit contributes to the accumulator word.
    localparam logic [DATA_WIDTH-1:0] ERR_WORD = 16'h0010;

    // Request kinds.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_IO   = 1'b1;

    // Interval reset values, one per rate select.
    localparam logic [CFG_WIDTH-1:0] INTERVAL_RESET [MAX_RATES] = '{
        26'd50, 26'd500, 26'd5000, 26'd50000,
        26'd500000, 26'd5000000, 26'd50000000, 26'd50000000
    };

    typedef enum logic [2:0] {
        OP_FLAG     = 3'd0,
        OP_SKIP_CLR = 3'd1,
        OP_SKIP_SET = 3'd2,
        OP_MERGE    = 3'd3,
        OP_LOAD     = 3'd4,
        OP_OUTPUT   = 3'd5,
        OP_CONTROL  = 3'd6,
        OP_NONE     = 3'd7
    } io_op_t;

    typedef struct packed {
        logic                  req_type;
        io_op_t                io_op;
        logic                  hold_clear;
        logic                  clear_select;
        logic [DATA_WIDTH-1:0] data_in;
    } tbg_req_t;

endpackage

[design/tbg_regs.sv]
// ----------------------------------------------------------------------------
// tbg_regs: interval register file
// Holds one interval per rate and returns the interval for the current rate
// select, clamped in index and saturated to the counter width.
// ----------------------------------------------------------------------------
module tbg_regs #(
    parameter int COUNT_WIDTH = tbg_pkg::DEF_COUNT_WIDTH,
    parameter int NUM_RATES   = tbg_pkg::DEF_NUM_RATES
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tbg_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [tbg_pkg::CFG_WIDTH-1:0]        cfg_data,
    input  logic [tbg_pkg::RATE_SEL_WIDTH-1:0]   rate_select,
    output logic [COUNT_WIDTH-1:0]               interval
);
    import tbg_pkg::*;

    localparam int IDX_W  = $clog2(NUM_RATES);
    localparam int WIDE_W = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    logic [CFG_WIDTH-1:0] interval_reg [NUM_RATES];
    logic [IDX_W-1:0]     rd_idx;
    logic [WIDE_W-1:0]    iv_wide;
    logic [WIDE_W-1:0]    max_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_RATES; i++)
            begin
                interval_reg[i] <= INTERVAL_RESET[i];
            end
        end
        else if (cfg_we && (cfg_index < CFG_INDEX_WIDTH'(NUM_RATES)))
        begin
            interval_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
        end
    end

    // Rate selects past the last implemented rate use the last one.
    always_comb
    begin
        if ({1'b0, rate_select} >= (RATE_SEL_WIDTH + 1)'(NUM_RATES))
        begin
            rd_idx = IDX_W'(NUM_RATES - 1);
        end
        else
        begin
            rd_idx = rate_select[IDX_W-1:0];
        end
    end

    assign iv_wide  = WIDE_W'(interval_reg[rd_idx]);
    assign max_wide = WIDE_W'({COUNT_WIDTH{1'b1}});
    assign interval = (iv_wide > max_wide) ? COUNT_WIDTH'(max_wide) : COUNT_WIDTH'(iv_wide);

endmodule

[design/tbg_core.sv]
// ----------------------------------------------------------------------------
// tbg_core: clock state and result register
// Applies one request to the clock state and registers the result word.
// ----------------------------------------------------------------------------
module tbg_core #(
    parameter int COUNT_WIDTH = tbg_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  tbg_pkg::tbg_req_t                   item,
    output logic                                item_ready,
    input  logic [COUNT_WIDTH-1:0]              interval,
    output logic [tbg_pkg::RATE_SEL_WIDTH-1:0]  rate_select,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tbg_pkg::DATA_WIDTH-1:0]      data_out,
    output logic                                skip,
    output logic                                flag_out,
    output logic                                control_out,
    output logic                                error_out
);
    import tbg_pkg::*;

    logic [RATE_SEL_WIDTH-1:0] rate_select_reg, rate_select_next;
    logic                      control_reg, control_next;
    logic                      flag_reg, flag_next;
    logic                      error_reg, error_next;
    logic [COUNT_WIDTH-1:0]    countdown_reg, countdown_next;
    logic                      out_valid_reg;
    logic [DATA_WIDTH-1:0]     out_data_reg, out_data_next;
    logic                      out_skip_reg, out_skip_next;
    logic                      advance;

    assign item_ready = !out_valid_reg || out_ready;
    assign advance    = item_valid && item_ready;

    always_comb
    begin
        rate_select_next = rate_select_reg;
        control_next     = control_reg;
        flag_next        = flag_reg;
        error_next       = error_reg;
        countdown_next   = countdown_reg;
        out_data_next    = item.data_in;
        out_skip_next    = 1'b0;

        if (item.req_type == REQ_TICK)
        begin
            out_data_next = '0;
            if (control_reg)
            begin
                if (countdown_reg <= COUNT_WIDTH'(1))
                begin
                    // Expiry: an already set flag means the program missed one.
                    error_next     = error_reg | flag_reg;
                    flag_next      = 1'b1;
                    countdown_next = interval;
                end
                else
                begin
                    countdown_next = countdown_reg - COUNT_WIDTH'(1);
                end
            end
        end
        else
        begin
            unique case (item.io_op)
                OP_FLAG:     flag_next = 1'b1;
                OP_SKIP_CLR: out_skip_next = !flag_reg;
                OP_SKIP_SET: out_skip_next = flag_reg;
                OP_MERGE:    out_data_next = item.data_in | (error_reg ? ERR_WORD : '0);
                OP_LOAD:     out_data_next = error_reg ? ERR_WORD : '0;
                OP_OUTPUT:   rate_select_next = item.data_in[RATE_SEL_WIDTH-1:0];
                OP_CONTROL:
                begin
                    if (item.clear_select)
                    begin
                        control_next   = 1'b0;
                        countdown_next = '0;
                    end
                    else
                    begin
                        control_next   = 1'b1;
                        error_next     = 1'b0;
                        countdown_next = interval;
                    end
                end
                OP_NONE:     out_data_next = item.data_in;
                default:     out_data_next = item.data_in;
            endcase
            if (item.hold_clear && (item.io_op != OP_SKIP_CLR) && (item.io_op != OP_SKIP_SET))
            begin
                flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_select_reg <= '0;
            control_reg     <= 1'b0;
            flag_reg        <= 1'b1;
            error_reg       <= 1'b0;
            countdown_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                rate_select_reg <= rate_select_next;
                control_reg     <= control_next;
                flag_reg        <= flag_next;
                error_reg       <= error_next;
                countdown_reg   <= countdown_next;
            end
            if (item_ready)
            begin
                out_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
            out_skip_reg <= out_skip_next;
        end
    end

    assign rate_select = rate_select_reg;
    assign out_valid   = out_valid_reg;
    assign data_out    = out_data_reg;
    assign skip        = out_skip_reg;
    // State registers only change when a result is loaded, so they match it.
    assign flag_out    = flag_reg;
    assign control_out = control_reg;
    assign error_out   = error_reg;

    a_stopped_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !control_reg |-> (countdown_reg == '0))
        else $error("countdown not zero while the clock is stopped");

    a_tick_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (item.req_type == REQ_TICK)) |=> ((out_data_reg == '0) && !out_skip_reg))
        else $error("tick produced a nonzero data word or a skip");

    a_error_only_on_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(error_reg) |-> $past(advance && (item.req_type == REQ_TICK) && flag_reg))
        else $error("overrun error set without an expiry on a set flag");

    a_control_set_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (item.req_type == REQ_IO) && (item.io_op == OP_CONTROL)
            && !item.clear_select) |=> (control_reg && !error_reg))
        else $error("control set did not start the clock and clear the error");

endmodule

[design/time_base_generator.sv]
// ----------------------------------------------------------------------------
// time_base_generator: programmable interval clock behind I/O instructions
// Counts time-base ticks down from a selectable interval, raises the device
// flag on each expiry and decodes the flag, skip, merge, load, output and
// control instructions of the host.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   --------  ---------  -------------------  -----------------------------------------
//   request   in         in_valid / in_ready  req_type, io_op, hold_clear, clear_select,
//                                             data_in
//   result    out        out_valid/out_ready  data_out, skip, flag_out, control_out,
//                                             error_out
//   config    in         cfg_we               cfg_index, cfg_data (no read-back)
//
// Every request, tick or instruction, yields exactly one result. A request
// is taken into an input register, applied to the clock state by one level
// of logic and registered in the result register once that register is
// empty or its result is being taken.
// Sustained rate is one request per cycle while out_ready is high. While a finished result waits for
// out_ready, the input register still takes one more request if it is empty;
// once it holds a request, in_ready stays low until the result is taken.
// Reset is asynchronous and active low; after it the flag is set, the clock
// is stopped, the intervals hold their defaults, and no result is pending.
//
// The countdown state is held in the core and updated only when a request
// moves from the input register into the result register, so a stall on the
// result side simply holds everything in place.
// ----------------------------------------------------------------------------
module time_base_generator #(
    parameter int COUNT_WIDTH = tbg_pkg::DEF_COUNT_WIDTH,
    parameter int NUM_RATES   = tbg_pkg::DEF_NUM_RATES
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [2:0]                          io_op,
    input  logic                                hold_clear,
    input  logic                                clear_select,
    input  logic [tbg_pkg::DATA_WIDTH-1:0]      data_in,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tbg_pkg::DATA_WIDTH-1:0]      data_out,
    output logic                                skip,
    output logic                                flag_out,
    output logic                                control_out,
    output logic                                error_out,

    input  logic                                cfg_we,
    input  logic [tbg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tbg_pkg::CFG_WIDTH-1:0]       cfg_data
);
    import tbg_pkg::*;

    tbg_req_t                  in_item_reg;
    logic                      in_valid_reg;
    logic                      core_ready;
    logic [COUNT_WIDTH-1:0]    interval;
    logic [RATE_SEL_WIDTH-1:0] rate_select;

    // The input register refills whenever it is empty or its request moves on.
    assign in_ready = !in_valid_reg || core_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg.req_type     <= req_type;
            in_item_reg.io_op        <= io_op_t'(io_op);
            in_item_reg.hold_clear   <= hold_clear;
            in_item_reg.clear_select <= clear_select;
            in_item_reg.data_in      <= data_in;
        end
    end

    // Interval registers with rate select clamping and counter saturation.
    tbg_regs #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .NUM_RATES   (NUM_RATES)
    ) u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rate_select (rate_select),
        .interval    (interval)
    );

    // Clock state, instruction decode and the result register.
    tbg_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (in_valid_reg),
        .item        (in_item_reg),
        .item_ready  (core_ready),
        .interval    (interval),
        .rate_select (rate_select),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out),
        .skip        (skip),
        .flag_out    (flag_out),
        .control_out (control_out),
        .error_out   (error_out)
    );

endmodule

[test/tb_time_base_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_time_base_generator: self-checking bench for the interval clock
// Drives ticks and I/O instructions through the request channel, mirrors the
// countdown, flag, control and overrun state in a behavioral model, and checks
// every status word that comes back on the result channel.
// ----------------------------------------------------------------------------
module tb_time_base_generator;

    import tbg_pkg::*;

    // Cycles with no accepted request and no accepted result before the run
    // is declared hung. The slowest legal gap is a sender pause, a receiver
    // stall, the pipeline latency and the interval rewrites between phases, so
    // this is a wide margin.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 205;
    localparam int DRAIN_CYCLES    = 10;

    // One status word as the block reports it after a request.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] data;
        logic                  skip;
        logic                  flag;
        logic                  control;
        logic                  error;
    } status_t;

    // One row of the directed plan. When known is set the status word is
    // taken from the row itself; otherwise the model supplies it.
    typedef struct packed {
        logic                  kind;
        io_op_t                op;
        logic                  hold;
        logic                  clr;
        logic [DATA_WIDTH-1:0] data;
        logic                  known;
        status_t               want;
    } plan_row_t;

    localparam status_t ANY = '0;

    // The directed part runs with interval 0 = 2 and interval 1 = 0, so a
    // restart on rate 0 expires on the second tick and rate 1 on every tick.
    localparam int PLAN_LEN = 24;
    localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        // Ticks right after reset: clock stopped, flag set, nothing moves.
        '{REQ_TICK, OP_NONE,     1'b0, 1'b0, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{REQ_TICK, OP_CONTROL,  1'b1, 1'b0, 16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b1, 1'b0, 1'b0}},
        // Skips never clear the flag, even with the hold/clear bit.
        '{REQ_IO,   OP_SKIP_CLR, 1'b0, 1'b0, 16'hFFFF, 1'b1, '{16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{REQ_IO,   OP_SKIP_SET, 1'b1, 1'b0, 16'h0000, 1'b1, '{16'h0000, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{REQ_IO,   OP_LOAD,     1'b0, 1'b0, 16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{REQ_IO,   OP_MERGE,    1'b1, 1'b0, 16'hFFEF, 1'b1, '{16'hFFEF, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{REQ_IO,   OP_SKIP_CLR, 1'b0, 1'b0, 16'h1234, 1'b1, '{16'h1234, 1'b1, 1'b0, 1'b0, 1'b0}},
        // Flag with hold/clear never sets the flag first.
        '{REQ_IO,   OP_FLAG,     1'b1, 1'b0, 16'h5A5A, 1'b1, '{16'h5A5A, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{REQ_IO,   OP_FLAG,     1'b0, 1'b0, 16'hA5A5, 1'b1, '{16'hA5A5, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{REQ_IO,   OP_NONE,     1'b1, 1'b1, 16'h8001, 1'b1, '{16'h8001, 1'b0, 1'b0, 1'b0, 1'b0}},
        // Start on rate 0, run through one expiry and then an overrun.
        '{REQ_IO,   OP_CONTROL,  1'b0, 1'b0, 16'h0000, 1'b0, ANY},
        '{REQ_TICK, OP_NONE,     1'b0, 1'b0, 16'h0000, 1'b0, ANY},
        '{REQ_TICK, OP_NONE,     1'b0, 1'b0, 16'h0000, 1'b0, ANY},
        '{REQ_TICK, OP_NONE,     1'b0, 1'b0, 16'h0000, 1'b0, ANY},
        '{REQ_TICK, OP_NONE,     1'b0, 1'b0, 16'h0000, 1'b0, ANY},
        // The overrun bit shows up as 16 on merge and load.
        '{REQ_IO,   OP_MERGE,    1'b0, 1'b0, 16'h0000, 1'b0, ANY},
        '{REQ_IO,   OP_LOAD,     1'b0, 1'b0, 16'h0000, 1'b0, ANY},
        // Only the low three bits of the word pick the rate.
        '{REQ_IO,   OP_OUTPUT,   1'b0, 1'b0, 16'hFFF9, 1'b0, ANY},
        // Restart clears the overrun; a zero interval expires every tick.
        '{REQ_IO,   OP_CONTROL,  1'b0, 1'b0, 16'h0000, 1'b0, ANY},
        '{REQ_TICK, OP_NONE,     1'b0, 1'b0, 16'h0000, 1'b0, ANY},
        '{REQ_TICK, OP_NONE,     1'b0, 1'b0, 16'h0000, 1'b0, ANY},
        // Stop the clock; a tick then changes nothing.
        '{REQ_IO,   OP_CONTROL,  1'b0, 1'b1, 16'h0000, 1'b0, ANY},
        '{REQ_TICK, OP_NONE,     1'b0, 1'b0, 16'h0000, 1'b0, ANY},
        '{REQ_IO,   OP_SKIP_SET, 1'b1, 1'b0, 16'hC3C3, 1'b0, ANY}
    };

    // Clock, reset and every block input start from a known value.
    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       req_type     = REQ_TICK;
    logic [2:0]                 io_op        = OP_NONE;
    logic                       hold_clear   = 1'b0;
    logic                       clear_select = 1'b0;
    logic [DATA_WIDTH-1:0]      data_in      = '0;
    logic                       out_ready    = 1'b0;
    logic                       cfg_we       = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index    = '0;
    logic [CFG_WIDTH-1:0]       cfg_data     = '0;

    logic                       in_ready;
    logic                       out_valid;
    logic [DATA_WIDTH-1:0]      data_out;
    logic                       skip;
    logic                       flag_out;
    logic                       control_out;
    logic                       error_out;

    // Mirror of the clock state and of the interval registers.
    logic [CFG_WIDTH-1:0]       interval_tbl [MAX_RATES];
    logic [RATE_SEL_WIDTH-1:0]  rate_sel   = '0;
    logic                       run_bit    = 1'b0;
    logic                       flag_bit   = 1'b1;
    logic                       error_bit  = 1'b0;
    logic [CFG_WIDTH-1:0]       countdown  = '0;

    // Status words still owed by the block, oldest first.
    status_t                    status_queue [$];

    // Idling controls: the sender may pause before each request and the receiver may stall after each result.
    bit                         sender_idles   = 1'b1;
    bit                         receiver_idles = 1'b1;
    int                         stall_left     = 0;

    int                         mismatches     = 0;
    int                         requests_sent  = 0;
    int                         ticks_sent     = 0;
    int                         expiries       = 0;
    int                         overruns       = 0;
    int                         skips_taken    = 0;
    int                         settings_used  = 0;
    int                         quiet_cycles   = 0;

    time_base_generator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .io_op        (io_op),
        .hold_clear   (hold_clear),
        .clear_select (clear_select),
        .data_in      (data_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_out     (data_out),
        .skip         (skip),
        .flag_out     (flag_out),
        .control_out  (control_out),
        .error_out    (error_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advances the mirrored clock by one request and returns the status word
    // the block must report for it. A tick only matters while control is set;
    // at expiry the flag is raised (an overrun if it was already up) and the
    // countdown reloads from the selected interval, so expiry is periodic.
    // A zero interval reloads zero and therefore expires on every tick.
    function automatic status_t clock_step(tbg_req_t r);
        status_t s;
        bit      may_clear;
        s         = '0;
        may_clear = 1'b1;
        if (r.req_type == REQ_TICK)
        begin
            may_clear = 1'b0;
            ticks_sent++;
            if (run_bit)
            begin
                if (countdown <= 1)
                begin
                    if (flag_bit)
                    begin
                        error_bit = 1'b1;
                        overruns++;
                    end
                    flag_bit  = 1'b1;
                    countdown = interval_tbl[rate_sel];
                    expiries++;
                end
                else
                begin
                    countdown = countdown - 1'b1;
                end
            end
        end
        else
        begin
            s.data = r.data_in;
            case (r.io_op)
                OP_FLAG:
                begin
                    if (!r.hold_clear)
                        flag_bit = 1'b1;
                end
                OP_SKIP_CLR:
                begin
                    s.skip    = !flag_bit;
                    may_clear = 1'b0;
                end
                OP_SKIP_SET:
                begin
                    s.skip    = flag_bit;
                    may_clear = 1'b0;
                end
                OP_MERGE:
                    s.data = r.data_in | (error_bit ? ERR_WORD : '0);
                OP_LOAD:
                    s.data = error_bit ? ERR_WORD : '0;
                OP_OUTPUT:
                    rate_sel = r.data_in[RATE_SEL_WIDTH-1:0];
                OP_CONTROL:
                begin
                    if (r.clear_select)
                    begin
                        run_bit   = 1'b0;
                        countdown = '0;
                    end
                    else
                    begin
                        // Setting control restarts even a running clock.
                        run_bit   = 1'b1;
                        error_bit = 1'b0;
                        countdown = interval_tbl[rate_sel];
                    end
                end
                default:
                begin
                end
            endcase
            if (may_clear && r.hold_clear)
                flag_bit = 1'b0;
            if (s.skip)
                skips_taken++;
        end
        s.flag    = flag_bit;
        s.control = run_bit;
        s.error   = error_bit;
        return s;
    endfunction

    // Presents one request, waits for the block to take it, and queues the
    // status word it owes. Called and left at a falling edge; valid is only
    // dropped when a pause is drawn, so it is never lowered and raised in the
    // same time step.
    task automatic send_request(input tbg_req_t r, input bit known, input status_t want);
        int      gap;
        status_t modeled;
        gap = sender_idles ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= r.req_type;
        io_op        <= r.io_op;
        hold_clear   <= r.hold_clear;
        clear_select <= r.clear_select;
        data_in      <= r.data_in;
        do
            @(posedge clk);
        while (!in_ready);
        // The model always advances; a typed row only overrides the word.
        modeled = clock_step(r);
        status_queue.push_back(known ? want : modeled);
        requests_sent++;
        @(negedge clk);
    endtask

    // Stops sending and waits until every owed status word has come back,
    // then lets the pipeline settle before the interval registers change.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (status_queue.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One register write per falling edge; the write enable stays high across
    // a batch and is dropped by close_writes.
    task automatic write_interval(input int index, input logic [CFG_WIDTH-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INDEX_WIDTH'(index);
        cfg_data  <= value;
        if (index < MAX_RATES)
            interval_tbl[index] = value;
        @(negedge clk);
    endtask

    task automatic close_writes();
        cfg_we <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    // Mostly short intervals so expiries and overruns happen often, with the
    // extremes (zero, all ones) and full-width random values mixed in.
    function automatic logic [CFG_WIDTH-1:0] draw_interval();
        logic [CFG_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = CFG_WIDTH'($urandom);
            default: v = CFG_WIDTH'($urandom_range(1, 12));
        endcase
        return v;
    endfunction

    // A random request: ticks dominate so the countdown actually runs, and
    // control is set far more often than it is cleared.
    function automatic tbg_req_t draw_request();
        tbg_req_t r;
        r.req_type     = ($urandom_range(0, 99) < 60) ? REQ_TICK : REQ_IO;
        r.io_op        = io_op_t'($urandom_range(0, 7));
        r.hold_clear   = 1'($urandom_range(0, 1));
        r.clear_select = ($urandom_range(0, 3) == 0);
        r.data_in      = DATA_WIDTH'($urandom);
        return r;
    endfunction

    // Result side: sample at the rising edge, compare against the oldest owed
    // word, and draw the stall before the next result.
    always @(posedge clk)
    begin : check_result
        status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            stall_left = receiver_idles ? $urandom_range(0, 10) : 0;
            if (status_queue.size() == 0)
            begin
                $error("result with nothing owed: data_out %h", data_out);
                mismatches++;
            end
            else
            begin
                want = status_queue.pop_front();
                if (data_out !== want.data)
                begin
                    $error("data_out: expected %h, got %h", want.data, data_out);
                    mismatches++;
                end
                if (skip !== want.skip)
                begin
                    $error("skip: expected %b, got %b", want.skip, skip);
                    mismatches++;
                end
                if (flag_out !== want.flag)
                begin
                    $error("flag_out: expected %b, got %b", want.flag, flag_out);
                    mismatches++;
                end
                if (control_out !== want.control)
                begin
                    $error("control_out: expected %b, got %b", want.control, control_out);
                    mismatches++;
                end
                if (error_out !== want.error)
                begin
                    $error("error_out: expected %b, got %b", want.error, error_out);
                    mismatches++;
                end
            end
        end
    end

    // Ready changes only at the falling edge.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Any accepted request or result counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        tbg_req_t r;
        int       mode;
        interval_tbl = INTERVAL_RESET;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. The block is idle after reset, so the intervals it
        // needs are written first; index 12 is out of range and must be
        // ignored.
        write_interval(0, 26'd2);
        write_interval(1, 26'd0);
        write_interval(2, '1);
        write_interval(7, 26'd1);
        write_interval(12, 26'h2AAAAAA);
        close_writes();
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            r.req_type     = DIRECTED_PLAN[i].kind;
            r.io_op        = DIRECTED_PLAN[i].op;
            r.hold_clear   = DIRECTED_PLAN[i].hold;
            r.clear_select = DIRECTED_PLAN[i].clr;
            r.data_in      = DIRECTED_PLAN[i].data;
            send_request(r, DIRECTED_PLAN[i].known, DIRECTED_PLAN[i].want);
        end

        // Random phases. Each one drains the block completely (the sender
        // holds off until nothing is owed), rewrites all eight intervals plus
        // one out-of-range index, and varies which side idles so that some
        // stretches run back to back.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_until_idle();
            for (int k = 0; k < MAX_RATES; k++)
                write_interval(k, draw_interval());
            write_interval($urandom_range(MAX_RATES, 15), CFG_WIDTH'($urandom));
            close_writes();

            mode           = p % 4;
            sender_idles   = (mode != 1) && (mode != 3);
            receiver_idles = (mode != 2) && (mode != 3);

            // Open with a well-formed start: pick a rate, then set control.
            r              = '0;
            r.req_type     = REQ_IO;
            r.io_op        = OP_OUTPUT;
            r.data_in      = DATA_WIDTH'($urandom);
            send_request(r, 1'b0, ANY);
            r.io_op        = OP_CONTROL;
            r.clear_select = 1'b0;
            r.data_in      = DATA_WIDTH'($urandom);
            send_request(r, 1'b0, ANY);

            for (int i = 2; i < ITEMS_PER_PHASE; i++)
                send_request(draw_request(), 1'b0, ANY);
        end

        // Drain: every owed word must arrive, then the bench keeps watching to catch
        // a result that should never have been produced.
        in_valid <= 1'b0;
        while (status_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d requests (%0d ticks) under %0d interval settings.",
                 requests_sent, ticks_sent, settings_used);
        $display("Saw %0d expiries, %0d overruns and %0d skips taken.",
                 expiries, overruns, skips_taken);
        if (mismatches == 0 && status_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
design/tbg_pkg.sv
design/tbg_regs.sv
design/tbg_core.sv
design/time_base_generator.sv
test/tb_time_base_generator.sv
